[rtl/amgs_pkg.sv]
// Shared constants, types and helper functions of the adjacency matrix graph store.
package amgs_pkg;

    localparam int MAX_V  = 32;
    localparam int ID_W   = 31;
    localparam int CMD_W  = 2;
    localparam int IDX_W  = $clog2(MAX_V);
    localparam int CNT_W  = $clog2(MAX_V + 1);
    localparam int EC_W   = $clog2(MAX_V * (MAX_V - 1) / 2 + 1);
    localparam int VT_W   = 6;
    localparam int ET_W   = 9;

    localparam logic [CMD_W-1:0] CMD_ADD_V = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_E = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_E = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CHECK = 2'd3;

    typedef struct packed {
        logic [MAX_V-1:0] hit_a;
        logic [MAX_V-1:0] hit_b;
    } t_lookup;

    function automatic logic [IDX_W-1:0] onehot_to_idx(logic [MAX_V-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < MAX_V; i++) begin
            if (v[i]) begin
                idx = idx | IDX_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [VT_W-1:0] to_vt(logic [CNT_W-1:0] v);
        return VT_W'(v);
    endfunction

    function automatic logic [ET_W-1:0] to_et(logic [EC_W-1:0] v);
        return ET_W'(v);
    endfunction

endpackage

[rtl/amgs_if.sv]
// Command and response channel interfaces of the graph store.
interface amgs_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [amgs_pkg::CMD_W-1:0]   cmd;
    logic [amgs_pkg::ID_W-1:0]    id_a;
    logic [amgs_pkg::ID_W-1:0]    id_b;

    modport source (output valid, output cmd, output id_a, output id_b, input ready);
    modport sink   (input valid, input cmd, input id_a, input id_b, output ready);
endinterface

interface amgs_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic [amgs_pkg::VT_W-1:0]    vertex_total;
    logic [amgs_pkg::ET_W-1:0]    edge_total;

    modport source (output valid, output ok, output vertex_total, output edge_total,
                    input ready);
    modport sink   (input valid, input ok, input vertex_total, input edge_total,
                    output ready);
endinterface

[rtl/amgs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module amgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/amgs_id_table.sv]
// Vertex id registers with parallel lookup of two keys.
module amgs_id_table (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [amgs_pkg::IDX_W-1:0]  i_widx,
    input  logic [amgs_pkg::ID_W-1:0]   i_wid,
    input  logic [amgs_pkg::CNT_W-1:0]  i_used,
    input  logic [amgs_pkg::ID_W-1:0]   i_key_a,
    input  logic [amgs_pkg::ID_W-1:0]   i_key_b,
    output amgs_pkg::t_lookup           o_lookup
);

    logic [amgs_pkg::ID_W-1:0] r_ids [amgs_pkg::MAX_V];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_ids[i_widx] <= i_wid;
        end
    end

    always_comb begin
        for (int i = 0; i < amgs_pkg::MAX_V; i++) begin
            o_lookup.hit_a[i] = (i < int'(i_used)) && (i_key_a != '0) && (r_ids[i] == i_key_a);
            o_lookup.hit_b[i] = (i < int'(i_used)) && (i_key_b != '0) && (r_ids[i] == i_key_b);
        end
    end

endmodule

[rtl/adjacency_matrix_graph_store_core.sv]
// Top level of the adjacency matrix graph store: command sequencer and row memory.
//
// Usage: commands arrive on i_cmd (cmd, id_a, id_b) and each produces exactly one
// response on o_rsp (ok, vertex_total, edge_total), both valid/ready channels.
// Commands: add vertex, add edge, delete edge, check vertex.
// Vertex ids sit in registers and are matched against both ids in parallel when a
// command is taken; adjacency rows sit in one memory with one read and one write port.
// Vertex commands and failed edge commands finish in the execute state, a delete of
// an absent edge finishes after the first row is read, and an edge update reads and
// rewrites the two affected rows in turn through the read and the write port.
// One command is in flight at a time, so no new command is taken until the current
// one has finished and its response has been or is being accepted.
// Reset clears both counts; the id registers and the row memory are not cleared,
// since a row is zeroed when its vertex is added and only stored ids are matched.
// When the receiver stalls, the response is held in the output register and no new
// command is taken until it is accepted (a command is taken in the cycle it drains).
module adjacency_matrix_graph_store_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    amgs_cmd_if.sink      i_cmd,
    amgs_rsp_if.source    o_rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RDA  = 2'd2;
    localparam logic [1:0] S_RDB  = 2'd3;

    logic [1:0]                      r_state, n_state;
    logic [amgs_pkg::CMD_W-1:0]      r_cmd, n_cmd;
    logic [amgs_pkg::ID_W-1:0]       r_id_a, n_id_a;
    logic                            r_a_nz, n_a_nz;
    amgs_pkg::t_lookup               r_hit, n_hit;
    logic [amgs_pkg::IDX_W-1:0]      r_pa, n_pa;
    logic [amgs_pkg::IDX_W-1:0]      r_pb, n_pb;
    logic                            r_bit, n_bit;
    logic [amgs_pkg::CNT_W-1:0]      r_used, n_used;
    logic [amgs_pkg::EC_W-1:0]       r_edges, n_edges;
    logic                            r_ov, n_ov;
    logic                            r_ok, n_ok;
    logic [amgs_pkg::VT_W-1:0]       r_vt, n_vt;
    logic [amgs_pkg::ET_W-1:0]       r_et, n_et;

    amgs_pkg::t_lookup               lookup;
    logic                            in_acc;
    logic                            finish;
    logic                            fin_ok;
    logic                            tab_we;
    logic                            ram_we;
    logic [amgs_pkg::IDX_W-1:0]      ram_waddr;
    logic [amgs_pkg::MAX_V-1:0]      ram_wdata;
    logic [amgs_pkg::IDX_W-1:0]      ram_raddr;
    logic [amgs_pkg::MAX_V-1:0]      ram_rdata;
    logic                            is_add;
    logic                            cur_bit;

    amgs_id_table u_ids (
        .i_clk    (i_clk),
        .i_we     (tab_we),
        .i_widx   (r_used[amgs_pkg::IDX_W-1:0]),
        .i_wid    (r_id_a),
        .i_used   (r_used),
        .i_key_a  (i_cmd.id_a),
        .i_key_b  (i_cmd.id_b),
        .o_lookup (lookup)
    );

    amgs_ram #(
        .WIDTH (amgs_pkg::MAX_V),
        .DEPTH (amgs_pkg::MAX_V)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_cmd.ready        = (r_state == S_IDLE) && (!r_ov || o_rsp.ready);
    assign in_acc             = i_cmd.valid && i_cmd.ready;
    assign o_rsp.valid        = r_ov;
    assign o_rsp.ok           = r_ok;
    assign o_rsp.vertex_total = r_vt;
    assign o_rsp.edge_total   = r_et;

    assign is_add  = (r_cmd == amgs_pkg::CMD_ADD_E);
    assign cur_bit = |(ram_rdata & r_hit.hit_b);

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_id_a    = r_id_a;
        n_a_nz    = r_a_nz;
        n_hit     = r_hit;
        n_pa      = r_pa;
        n_pb      = r_pb;
        n_bit     = r_bit;
        n_used    = r_used;
        n_edges   = r_edges;
        finish    = 1'b0;
        fin_ok    = 1'b0;
        tab_we    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_pa;
        ram_wdata = '0;
        ram_raddr = r_pa;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd   = i_cmd.cmd;
                    n_id_a  = i_cmd.id_a;
                    n_a_nz  = (i_cmd.id_a != '0);
                    n_hit   = lookup;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_pa      = amgs_pkg::onehot_to_idx(r_hit.hit_a);
                n_pb      = amgs_pkg::onehot_to_idx(r_hit.hit_b);
                ram_raddr = n_pa;
                unique case (r_cmd) inside
                    amgs_pkg::CMD_ADD_V: begin
                        finish  = 1'b1;
                        n_state = S_IDLE;
                        if (r_a_nz && !(|r_hit.hit_a)
                            && (r_used < amgs_pkg::CNT_W'(amgs_pkg::MAX_V))) begin
                            tab_we    = 1'b1;
                            ram_we    = 1'b1;
                            ram_waddr = r_used[amgs_pkg::IDX_W-1:0];
                            ram_wdata = '0;
                            n_used    = r_used + 1'b1;
                            fin_ok    = 1'b1;
                        end
                    end
                    amgs_pkg::CMD_CHECK: begin
                        finish  = 1'b1;
                        fin_ok  = |r_hit.hit_a;
                        n_state = S_IDLE;
                    end
                    amgs_pkg::CMD_ADD_E, amgs_pkg::CMD_DEL_E: begin
                        if ((|r_hit.hit_a) && (|r_hit.hit_b)
                            && (r_hit.hit_a != r_hit.hit_b)) begin
                            n_state = S_RDA;
                        end else begin
                            finish  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        finish  = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_RDA: begin
                if (!is_add && !cur_bit) begin
                    finish  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pa;
                    ram_wdata = is_add ? (ram_rdata | r_hit.hit_b)
                                       : (ram_rdata & ~r_hit.hit_b);
                    ram_raddr = r_pb;
                    n_bit     = cur_bit;
                    n_state   = S_RDB;
                end
            end
            S_RDB: begin
                ram_we    = 1'b1;
                ram_waddr = r_pb;
                ram_wdata = is_add ? (ram_rdata | r_hit.hit_a)
                                   : (ram_rdata & ~r_hit.hit_a);
                if (is_add) begin
                    if (!r_bit) begin
                        n_edges = r_edges + 1'b1;
                    end
                end else if (r_edges != '0) begin
                    n_edges = r_edges - 1'b1;
                end
                finish  = 1'b1;
                fin_ok  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ov = r_ov;
        n_ok = r_ok;
        n_vt = r_vt;
        n_et = r_et;
        if (finish) begin
            n_ov = 1'b1;
            n_ok = fin_ok;
            n_vt = amgs_pkg::to_vt(n_used);
            n_et = amgs_pkg::to_et(n_edges);
        end else if (o_rsp.ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_edges <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_edges <= n_edges;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_id_a <= n_id_a;
        r_a_nz <= n_a_nz;
        r_hit  <= n_hit;
        r_pa   <= n_pa;
        r_pb   <= n_pb;
        r_bit  <= n_bit;
        r_ok   <= n_ok;
        r_vt   <= n_vt;
        r_et   <= n_et;
    end

endmodule
